/* sv/nmea_sentence_parser_macros.svh */
// assertion macros for the port-level checker
`ifndef NMEA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_SENTENCE_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nsp_pkg.sv */
// types, constants and helper functions of the nmea sentence parser
`default_nettype none

package nsp_pkg;

    // ascii codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    // address words
    localparam logic [39:0] ADDR_GNGGA = 40'h474E474741;
    localparam logic [39:0] ADDR_GNGLL = 40'h474E474C4C;
    localparam logic [39:0] ADDR_GPGSA = 40'h4750475341;

    // sentence kinds
    localparam logic [1:0] KIND_GGA  = 2'd0;
    localparam logic [1:0] KIND_GLL  = 2'd1;
    localparam logic [1:0] KIND_GSA  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // limits
    localparam logic [29:0] LAT_MAX   = 30'd90000000;
    localparam logic [29:0] LON_MAX   = 30'd180000000;
    localparam logic [29:0] INT_CAP   = 30'd99999999;
    localparam logic [17:0] MILLI_MAX = 18'd131071;
    localparam logic [13:0] HDOP_MAX  = 14'd9999;
    localparam logic [6:0]  SATS_MAX  = 7'd99;
    localparam logic [23:0] UTC_MAX   = 24'd8639999;
    localparam logic [20:0] ALT_HI    = 21'd1000000;
    localparam logic [20:0] ALT_LO_MAG = 21'd100000;
    // ceil(2^24 / 3), exact floor(x/3) for x below 2^23
    localparam logic [22:0] RECIP3    = 23'd5592406;

    // sentence framing states
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_BODY    = 6'b000010,
        PH_HEX_HI  = 6'b000100,
        PH_HEX_LO  = 6'b001000,
        PH_WAIT_CR = 6'b010000,
        PH_WAIT_LF = 6'b100000
    } phase_t;

    // meaning of the current field
    typedef enum logic [3:0] {
        R_NONE, R_ADDR, R_TIME, R_LAT, R_LON, R_SIDE0, R_SIDE1,
        R_QUAL, R_SATS, R_HDOP, R_ALT, R_GSAFIX, R_PRN
    } role_t;

    // one result word
    typedef struct packed {
        logic [1:0]         sentence_kind;
        logic               accepted;
        logic [26:0]        latitude_micro;
        logic               lat_south;
        logic [27:0]        longitude_micro;
        logic               lon_west;
        logic signed [20:0] altitude_dm;
        logic [13:0]        hdop_centi;
        logic [6:0]         satellites;
        logic               fix_valid;
        logic [23:0]        utc_centis;
    } result_t;

    // field role from field position and sentence kind
    function automatic role_t role_of(input logic [6:0] f, input logic [1:0] kind);
        role_t r;
        r = R_NONE;
        if (f == 7'd0) begin
            r = R_ADDR;
        end else if (kind == KIND_GGA) begin
            case (f)
                7'd1:    r = R_TIME;
                7'd2:    r = R_LAT;
                7'd3:    r = R_SIDE0;
                7'd4:    r = R_LON;
                7'd5:    r = R_SIDE1;
                7'd6:    r = R_QUAL;
                7'd7:    r = R_SATS;
                7'd8:    r = R_HDOP;
                7'd9:    r = R_ALT;
                default: r = R_NONE;
            endcase
        end else if (kind == KIND_GLL) begin
            case (f)
                7'd1:    r = R_LAT;
                7'd2:    r = R_SIDE0;
                7'd3:    r = R_LON;
                7'd4:    r = R_SIDE1;
                default: r = R_NONE;
            endcase
        end else if (kind == KIND_GSA) begin
            if (f == 7'd2) begin
                r = R_GSAFIX;
            end else if (f inside {[7'd3:7'd14]}) begin
                r = R_PRN;
            end
        end
        return r;
    endfunction

    // hex digit: valid flag over value
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h = {1'b1, 4'(c - CH_0)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            h = {1'b1, 4'(c - CH_UA + 8'd10)};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            h = {1'b1, 4'(c - CH_LA + 8'd10)};
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* sv/nsp_core.sv */
// sentence framing, field parsing and held position record
`default_nettype none

module nsp_core #(
    parameter int MAX_FIELDS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    output logic                 res_valid,
    output nsp_pkg::result_t     res
);

    localparam int FW = $clog2(MAX_FIELDS);

    nsp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  rsum_reg, rsum_next;
    logic [FW-1:0] fnum_reg, fnum_next;
    logic [3:0]  cif_reg, cif_next;
    logic [39:0] addr_reg, addr_next;
    logic [1:0]  kind_reg, kind_next;
    logic [9:0]  deg0_reg, deg0_next, deg1_reg, deg1_next;
    logic [16:0] milli0_reg, milli0_next, milli1_reg, milli1_next;
    logic        qual_reg, qual_next;
    logic [6:0]  sats_sh_reg, sats_sh_next;
    logic [13:0] hdop_sh_reg, hdop_sh_next;
    logic [20:0] alt_sh_reg, alt_sh_next;
    logic [7:0]  side0_reg, side0_next, side1_reg, side1_next;
    logic [3:0]  prn_reg, prn_next;
    logic [23:0] utc_sh_reg, utc_sh_next;
    logic        alt_nz_reg, alt_nz_next, hdop_nz_reg, hdop_nz_next;
    logic        deg_stop_reg, deg_stop_next;
    // number accumulator
    logic        n_neg_reg, n_neg_next, n_dot_reg, n_dot_next;
    logic        n_stop_reg, n_stop_next, n_nz_reg, n_nz_next, n_any_reg, n_any_next;
    logic [1:0]  n_frac_reg, n_frac_next;
    logic [26:0] n_int_reg, n_int_next;
    logic [9:0]  n_fv_reg, n_fv_next;
    // time digits hhhh mm ss
    logic [13:0] th_reg, th_next;
    logic [3:0]  tm1_reg, tm1_next, tm0_reg, tm0_next, ts1_reg, ts1_next, ts0_reg, ts0_next;
    // held record
    logic [26:0] hlat_reg, hlat_next;
    logic [27:0] hlon_reg, hlon_next;
    logic [20:0] halt_reg, halt_next;
    logic [13:0] hhdop_reg, hhdop_next;
    logic [6:0]  hsats_reg, hsats_next;
    logic        hfix_reg, hfix_next, hsouth_reg, hsouth_next, hwest_reg, hwest_next;
    logic [23:0] hutc_reg, hutc_next;
    // coordinate conversion, two registered steps
    logic [21:0] q0_reg, q1_reg;
    logic [29:0] micro0_reg, micro1_reg;

    logic        feed_ev, end_ev, commit_ev, acc;
    nsp_pkg::role_t role;
    logic [7:0]  c;
    logic [4:0]  hx;
    logic        is_dig;
    logic [3:0]  d;
    logic        num_go, sign_ok, dot_ok;
    logic [1:0]  fmax;
    logic [29:0] int_ext;
    logic [16:0] th_ext;
    logic [13:0] fv_ext;
    logic [9:0]  fs3, fs2, fs1;
    logic [17:0] milli_w;
    logic [23:0] utc_w;
    logic [6:0]  mm, ss;
    logic [19:0] hd_w;
    logic [20:0] alt_w;
    logic        side_ok;
    logic [45:0] prod0, prod1;

    assign c      = in_byte;
    assign hx     = nsp_pkg::hex_of(c);
    assign is_dig = (c >= nsp_pkg::CH_0) && (c <= nsp_pkg::CH_9);
    assign d      = 4'(c - nsp_pkg::CH_0);
    assign role   = nsp_pkg::role_of(7'(fnum_reg), kind_reg);

    // decimals of the number scaled to 3, 2 and 1 places
    always_comb
    begin
        case (n_frac_reg)
            2'd1:    fs3 = 10'(n_fv_reg * 10'd100);
            2'd2:    fs3 = 10'(n_fv_reg * 10'd10);
            2'd3:    fs3 = n_fv_reg;
            default: fs3 = 10'd0;
        endcase
        case (n_frac_reg)
            2'd1:    fs2 = 10'(n_fv_reg * 10'd10);
            2'd2:    fs2 = n_fv_reg;
            default: fs2 = 10'd0;
        endcase
        fs1 = (n_frac_reg == 2'd0) ? 10'd0 : n_fv_reg;
    end

    // framing, field parsing and record update
    always_comb
    begin
        phase_next = phase_reg;   xor_next = xor_reg;       rsum_next = rsum_reg;
        fnum_next = fnum_reg;     cif_next = cif_reg;       addr_next = addr_reg;
        kind_next = kind_reg;     deg0_next = deg0_reg;     deg1_next = deg1_reg;
        milli0_next = milli0_reg; milli1_next = milli1_reg; qual_next = qual_reg;
        sats_sh_next = sats_sh_reg; hdop_sh_next = hdop_sh_reg; alt_sh_next = alt_sh_reg;
        side0_next = side0_reg;   side1_next = side1_reg;   prn_next = prn_reg;
        utc_sh_next = utc_sh_reg; alt_nz_next = alt_nz_reg; hdop_nz_next = hdop_nz_reg;
        deg_stop_next = deg_stop_reg;
        n_neg_next = n_neg_reg;   n_dot_next = n_dot_reg;   n_stop_next = n_stop_reg;
        n_nz_next = n_nz_reg;     n_any_next = n_any_reg;   n_frac_next = n_frac_reg;
        n_int_next = n_int_reg;   n_fv_next = n_fv_reg;
        th_next = th_reg; tm1_next = tm1_reg; tm0_next = tm0_reg;
        ts1_next = ts1_reg; ts0_next = ts0_reg;
        hlat_next = hlat_reg;     hlon_next = hlon_reg;     halt_next = halt_reg;
        hhdop_next = hhdop_reg;   hsats_next = hsats_reg;   hfix_next = hfix_reg;
        hsouth_next = hsouth_reg; hwest_next = hwest_reg;   hutc_next = hutc_reg;
        feed_ev = 1'b0; end_ev = 1'b0; commit_ev = 1'b0; acc = 1'b0;
        num_go = 1'b0; sign_ok = 1'b0; dot_ok = 1'b0; fmax = 2'd0;
        int_ext = 30'd0; th_ext = 17'd0; fv_ext = 14'd0;
        milli_w = 18'd0; utc_w = 24'd0; mm = 7'd0; ss = 7'd0; hd_w = 20'd0; alt_w = 21'd0;
        side_ok = 1'b0;

        // frame state machine
        if (in_valid) begin
            if (c == nsp_pkg::CH_DOLLAR) begin
                phase_next = nsp_pkg::PH_BODY;
                xor_next = 8'd0; rsum_next = 8'd0; fnum_next = '0; cif_next = 4'd0;
                addr_next = 40'd0; kind_next = nsp_pkg::KIND_NONE;
                deg0_next = 10'd0; deg1_next = 10'd0; milli0_next = 17'd0; milli1_next = 17'd0;
                qual_next = 1'b0; sats_sh_next = 7'd0; hdop_sh_next = 14'd0; alt_sh_next = 21'd0;
                side0_next = 8'd0; side1_next = 8'd0; prn_next = 4'd0; utc_sh_next = 24'd0;
                alt_nz_next = 1'b0; hdop_nz_next = 1'b0; deg_stop_next = 1'b0;
                n_neg_next = 1'b0; n_dot_next = 1'b0; n_stop_next = 1'b0; n_nz_next = 1'b0;
                n_any_next = 1'b0; n_frac_next = 2'd0; n_int_next = 27'd0; n_fv_next = 10'd0;
                th_next = 14'd0; tm1_next = 4'd0; tm0_next = 4'd0; ts1_next = 4'd0; ts0_next = 4'd0;
            end else begin
                case (phase_reg)
                    nsp_pkg::PH_BODY:
                    begin
                        if (c == nsp_pkg::CH_STAR) begin
                            end_ev = 1'b1;
                            phase_next = nsp_pkg::PH_HEX_HI;
                        end else if (c == nsp_pkg::CH_CR || c == nsp_pkg::CH_LF) begin
                            phase_next = nsp_pkg::PH_IDLE;
                        end else begin
                            xor_next = xor_reg ^ c;
                            if (c == nsp_pkg::CH_COMMA) begin
                                if ((FW+1)'({1'b0, fnum_reg} + 1'b1) >= (FW+1)'(MAX_FIELDS)) begin
                                    phase_next = nsp_pkg::PH_IDLE;
                                end else begin
                                    end_ev = 1'b1;
                                end
                            end else begin
                                feed_ev = 1'b1;
                            end
                        end
                    end
                    nsp_pkg::PH_HEX_HI:
                    begin
                        if (hx[4]) begin
                            rsum_next = {hx[3:0], 4'd0};
                            phase_next = nsp_pkg::PH_HEX_LO;
                        end else begin
                            phase_next = nsp_pkg::PH_IDLE;
                        end
                    end
                    nsp_pkg::PH_HEX_LO:
                    begin
                        if (hx[4]) begin
                            rsum_next = {rsum_reg[7:4], hx[3:0]};
                            phase_next = nsp_pkg::PH_WAIT_CR;
                        end else begin
                            phase_next = nsp_pkg::PH_IDLE;
                        end
                    end
                    nsp_pkg::PH_WAIT_CR:
                    begin
                        phase_next = (c == nsp_pkg::CH_CR) ? nsp_pkg::PH_WAIT_LF
                                                           : nsp_pkg::PH_IDLE;
                    end
                    nsp_pkg::PH_WAIT_LF:
                    begin
                        phase_next = nsp_pkg::PH_IDLE;
                        commit_ev = (c == nsp_pkg::CH_LF) && (xor_reg == rsum_reg) &&
                                    (kind_reg != nsp_pkg::KIND_NONE);
                    end
                    default:
                    begin
                        phase_next = nsp_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        // character inside a field
        if (feed_ev) begin
            case (role)
                nsp_pkg::R_ADDR:
                begin
                    if (cif_reg < 4'd5) addr_next = {addr_reg[31:0], c};
                end
                nsp_pkg::R_TIME:
                begin
                    num_go = 1'b1; dot_ok = 1'b1; fmax = 2'd2;
                end
                nsp_pkg::R_LAT:
                begin
                    if (cif_reg < 4'd2) begin
                        if (!deg_stop_reg) begin
                            if (is_dig) deg0_next = 10'(deg0_reg * 10'd10 + 10'(d));
                            else deg_stop_next = 1'b1;
                        end
                    end else if (cif_reg < 4'd8) begin
                        num_go = 1'b1; dot_ok = 1'b1; fmax = 2'd3;
                    end
                end
                nsp_pkg::R_LON:
                begin
                    if (cif_reg < 4'd3) begin
                        if (!deg_stop_reg) begin
                            if (is_dig) deg1_next = 10'(deg1_reg * 10'd10 + 10'(d));
                            else deg_stop_next = 1'b1;
                        end
                    end else if (cif_reg < 4'd9) begin
                        num_go = 1'b1; dot_ok = 1'b1; fmax = 2'd3;
                    end
                end
                nsp_pkg::R_SIDE0:
                begin
                    if (cif_reg == 4'd0) side0_next = c;
                end
                nsp_pkg::R_SIDE1:
                begin
                    if (cif_reg == 4'd0) side1_next = c;
                end
                nsp_pkg::R_QUAL, nsp_pkg::R_SATS, nsp_pkg::R_GSAFIX:
                begin
                    num_go = 1'b1; sign_ok = 1'b1;
                end
                nsp_pkg::R_HDOP:
                begin
                    num_go = 1'b1; sign_ok = 1'b1; dot_ok = 1'b1; fmax = 2'd2;
                end
                nsp_pkg::R_ALT:
                begin
                    num_go = 1'b1; sign_ok = 1'b1; dot_ok = 1'b1; fmax = 2'd1;
                end
                default:
                begin
                end
            endcase
            if (cif_reg != 4'd15) cif_next = cif_reg + 4'd1;
        end

        // number accumulator step
        if (num_go && !n_stop_reg) begin
            if ((c == nsp_pkg::CH_MINUS || c == nsp_pkg::CH_PLUS) && sign_ok && !n_any_reg) begin
                n_neg_next = (c == nsp_pkg::CH_MINUS);
                n_any_next = 1'b1;
            end else if (is_dig) begin
                if (d != 4'd0) n_nz_next = 1'b1;
                if (!n_dot_reg) begin
                    int_ext = 30'(n_int_reg) * 30'd10 + 30'(d);
                    n_int_next = (int_ext > nsp_pkg::INT_CAP) ? 27'(nsp_pkg::INT_CAP)
                                                              : int_ext[26:0];
                    th_ext = 17'(th_reg) * 17'd10 + 17'(tm1_reg);
                    if (th_ext > 17'd9999) begin
                        th_next = 14'd9999; tm1_next = 4'd9; tm0_next = 4'd9;
                        ts1_next = 4'd9; ts0_next = 4'd9;
                    end else begin
                        th_next = th_ext[13:0]; tm1_next = tm0_reg; tm0_next = ts1_reg;
                        ts1_next = ts0_reg; ts0_next = d;
                    end
                end else if (n_frac_reg < fmax) begin
                    fv_ext = 14'(n_fv_reg) * 14'd10 + 14'(d);
                    n_fv_next = fv_ext[9:0];
                    n_frac_next = n_frac_reg + 2'd1;
                end
                n_any_next = 1'b1;
            end else if (c == nsp_pkg::CH_DOT && dot_ok && !n_dot_reg) begin
                n_dot_next = 1'b1;
                n_any_next = 1'b1;
            end else begin
                n_stop_next = 1'b1;
            end
        end

        // end of a field
        if (end_ev) begin
            case (role)
                nsp_pkg::R_ADDR:
                begin
                    if (cif_reg == 4'd5) begin
                        if (addr_reg == nsp_pkg::ADDR_GNGGA) kind_next = nsp_pkg::KIND_GGA;
                        else if (addr_reg == nsp_pkg::ADDR_GNGLL) kind_next = nsp_pkg::KIND_GLL;
                        else if (addr_reg == nsp_pkg::ADDR_GPGSA) kind_next = nsp_pkg::KIND_GSA;
                    end
                end
                nsp_pkg::R_TIME:
                begin
                    mm = 7'(tm1_reg * 7'd10 + 7'(tm0_reg));
                    ss = 7'(ts1_reg * 7'd10 + 7'(ts0_reg));
                    utc_w = 24'(th_reg[4:0]) * 24'd360000 + 24'(mm) * 24'd6000 +
                            24'(ss) * 24'd100 + 24'(fs2);
                    utc_sh_next = (th_reg >= 14'd24 || utc_w > nsp_pkg::UTC_MAX)
                                  ? nsp_pkg::UTC_MAX : utc_w;
                end
                nsp_pkg::R_LAT, nsp_pkg::R_LON:
                begin
                    milli_w = 18'(n_int_reg[7:0]) * 18'd1000 + 18'(fs3);
                    if (n_int_reg > 27'd131 || milli_w > nsp_pkg::MILLI_MAX) begin
                        milli_w = nsp_pkg::MILLI_MAX;
                    end
                    if (role == nsp_pkg::R_LAT) milli0_next = milli_w[16:0];
                    else milli1_next = milli_w[16:0];
                end
                nsp_pkg::R_QUAL:
                begin
                    qual_next = !n_neg_reg && (n_int_reg > 27'd0);
                end
                nsp_pkg::R_GSAFIX:
                begin
                    qual_next = !n_neg_reg && (n_int_reg > 27'd1);
                end
                nsp_pkg::R_SATS:
                begin
                    if (n_neg_reg) sats_sh_next = 7'd0;
                    else if (n_int_reg > 27'(nsp_pkg::SATS_MAX)) sats_sh_next = nsp_pkg::SATS_MAX;
                    else sats_sh_next = n_int_reg[6:0];
                end
                nsp_pkg::R_HDOP:
                begin
                    hdop_nz_next = n_nz_reg;
                    hd_w = 20'(n_int_reg[6:0]) * 20'd100 + 20'(fs2);
                    if (n_neg_reg) hdop_sh_next = 14'd0;
                    else if (n_int_reg > 27'd99 || hd_w > 20'(nsp_pkg::HDOP_MAX))
                        hdop_sh_next = nsp_pkg::HDOP_MAX;
                    else hdop_sh_next = hd_w[13:0];
                end
                nsp_pkg::R_ALT:
                begin
                    alt_nz_next = n_nz_reg;
                    alt_w = 21'(n_int_reg[16:0]) * 21'd10 + 21'(fs1);
                    if (n_neg_reg) begin
                        if (n_int_reg > 27'd100000 || alt_w > nsp_pkg::ALT_LO_MAG)
                            alt_sh_next = 21'd0 - nsp_pkg::ALT_LO_MAG;
                        else alt_sh_next = 21'd0 - alt_w;
                    end else begin
                        if (n_int_reg > 27'd100000 || alt_w > nsp_pkg::ALT_HI)
                            alt_sh_next = nsp_pkg::ALT_HI;
                        else alt_sh_next = alt_w;
                    end
                end
                nsp_pkg::R_PRN:
                begin
                    if (cif_reg != 4'd0) prn_next = prn_reg + 4'd1;
                end
                default:
                begin
                end
            endcase
            fnum_next = fnum_reg + 1'b1;
            cif_next = 4'd0;
            deg_stop_next = 1'b0;
            n_neg_next = 1'b0; n_dot_next = 1'b0; n_stop_next = 1'b0; n_nz_next = 1'b0;
            n_any_next = 1'b0; n_frac_next = 2'd0; n_int_next = 27'd0; n_fv_next = 10'd0;
            th_next = 14'd0; tm1_next = 4'd0; tm0_next = 4'd0; ts1_next = 4'd0; ts0_next = 4'd0;
        end

        // per-type checks and record update
        if (commit_ev) begin
            side_ok = (side0_reg == nsp_pkg::CH_S) || (side0_reg == nsp_pkg::CH_N);
            case (kind_reg)
                nsp_pkg::KIND_GSA:
                begin
                    hfix_next = qual_reg;
                    hsats_next = 7'(prn_reg);
                    acc = 1'b1;
                end
                nsp_pkg::KIND_GLL:
                begin
                    if (side_ok && deg0_reg != 10'd0 && deg1_reg != 10'd0 &&
                        milli0_reg != 17'd0 && milli1_reg != 17'd0) begin
                        hlat_next = (micro0_reg > nsp_pkg::LAT_MAX) ? 27'(nsp_pkg::LAT_MAX)
                                                                     : micro0_reg[26:0];
                        hlon_next = (micro1_reg > nsp_pkg::LON_MAX) ? 28'(nsp_pkg::LON_MAX)
                                                                     : micro1_reg[27:0];
                        hsouth_next = (side0_reg == nsp_pkg::CH_S);
                        hwest_next = (side1_reg == nsp_pkg::CH_W);
                        acc = 1'b1;
                    end
                end
                default:
                begin
                    hutc_next = utc_sh_reg;
                    if (side_ok && (deg0_reg != 10'd0 || milli0_reg != 17'd0) &&
                        (deg1_reg != 10'd0 || milli1_reg != 17'd0) &&
                        micro0_reg < nsp_pkg::LAT_MAX && micro1_reg < nsp_pkg::LON_MAX) begin
                        hlat_next = micro0_reg[26:0];
                        hlon_next = micro1_reg[27:0];
                        hsouth_next = (side0_reg == nsp_pkg::CH_S);
                        hwest_next = (side1_reg == nsp_pkg::CH_W);
                        if (alt_nz_reg) halt_next = alt_sh_reg;
                        hsats_next = sats_sh_reg;
                        hfix_next = qual_reg;
                        if (hdop_nz_reg) hhdop_next = hdop_sh_reg;
                        acc = 1'b1;
                    end
                end
            endcase
        end
    end

    // result word from the updated record
    assign res_valid           = commit_ev;
    assign res.sentence_kind   = kind_reg;
    assign res.accepted        = acc;
    assign res.latitude_micro  = hlat_next;
    assign res.lat_south       = hsouth_next;
    assign res.longitude_micro = hlon_next;
    assign res.lon_west        = hwest_next;
    assign res.altitude_dm     = $signed(halt_next);
    assign res.hdop_centi      = hhdop_next;
    assign res.satellites      = hsats_next;
    assign res.fix_valid       = hfix_next;
    assign res.utc_centis      = hutc_next;

    // micro-degrees = deg * 1e6 + floor(milli * 50 / 3), settled well before lf
    assign prod0 = 46'(23'(milli0_reg) * 23'd50) * 46'(nsp_pkg::RECIP3);
    assign prod1 = 46'(23'(milli1_reg) * 23'd50) * 46'(nsp_pkg::RECIP3);

    always_ff @(posedge clk)
    begin
        q0_reg <= prod0[45:24];
        q1_reg <= prod1[45:24];
        micro0_reg <= 30'(deg0_reg) * 30'd1000000 + 30'(q0_reg);
        micro1_reg <= 30'(deg1_reg) * 30'd1000000 + 30'(q1_reg);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= nsp_pkg::PH_IDLE;
            xor_reg <= 8'd0; rsum_reg <= 8'd0; fnum_reg <= '0; cif_reg <= 4'd0;
            addr_reg <= 40'd0; kind_reg <= nsp_pkg::KIND_NONE;
            deg0_reg <= 10'd0; deg1_reg <= 10'd0; milli0_reg <= 17'd0; milli1_reg <= 17'd0;
            qual_reg <= 1'b0; sats_sh_reg <= 7'd0; hdop_sh_reg <= 14'd0; alt_sh_reg <= 21'd0;
            side0_reg <= 8'd0; side1_reg <= 8'd0; prn_reg <= 4'd0; utc_sh_reg <= 24'd0;
            alt_nz_reg <= 1'b0; hdop_nz_reg <= 1'b0; deg_stop_reg <= 1'b0;
            n_neg_reg <= 1'b0; n_dot_reg <= 1'b0; n_stop_reg <= 1'b0; n_nz_reg <= 1'b0;
            n_any_reg <= 1'b0; n_frac_reg <= 2'd0; n_int_reg <= 27'd0; n_fv_reg <= 10'd0;
            th_reg <= 14'd0; tm1_reg <= 4'd0; tm0_reg <= 4'd0; ts1_reg <= 4'd0; ts0_reg <= 4'd0;
            hlat_reg <= 27'd0; hlon_reg <= 28'd0; halt_reg <= 21'd0; hhdop_reg <= 14'd0;
            hsats_reg <= 7'd0; hfix_reg <= 1'b0; hsouth_reg <= 1'b0; hwest_reg <= 1'b0;
            hutc_reg <= 24'd0;
        end else begin
            phase_reg <= phase_next;
            xor_reg <= xor_next; rsum_reg <= rsum_next; fnum_reg <= fnum_next;
            cif_reg <= cif_next; addr_reg <= addr_next; kind_reg <= kind_next;
            deg0_reg <= deg0_next; deg1_reg <= deg1_next;
            milli0_reg <= milli0_next; milli1_reg <= milli1_next;
            qual_reg <= qual_next; sats_sh_reg <= sats_sh_next; hdop_sh_reg <= hdop_sh_next;
            alt_sh_reg <= alt_sh_next; side0_reg <= side0_next; side1_reg <= side1_next;
            prn_reg <= prn_next; utc_sh_reg <= utc_sh_next;
            alt_nz_reg <= alt_nz_next; hdop_nz_reg <= hdop_nz_next;
            deg_stop_reg <= deg_stop_next;
            n_neg_reg <= n_neg_next; n_dot_reg <= n_dot_next; n_stop_reg <= n_stop_next;
            n_nz_reg <= n_nz_next; n_any_reg <= n_any_next; n_frac_reg <= n_frac_next;
            n_int_reg <= n_int_next; n_fv_reg <= n_fv_next;
            th_reg <= th_next; tm1_reg <= tm1_next; tm0_reg <= tm0_next;
            ts1_reg <= ts1_next; ts0_reg <= ts0_next;
            hlat_reg <= hlat_next; hlon_reg <= hlon_next; halt_reg <= halt_next;
            hhdop_reg <= hhdop_next; hsats_reg <= hsats_next; hfix_reg <= hfix_next;
            hsouth_reg <= hsouth_next; hwest_reg <= hwest_next; hutc_reg <= hutc_next;
        end
    end

endmodule

`default_nettype wire

/* sv/nmea_sentence_parser.sv */
// nmea sentence parser top level: input register, parser core, output skid stage
// lf byte -> byte register -> parse core -> output register (or skid) -> m_tvalid
// throughput: one byte per cycle if s_tready; the byte register feeds the parse logic
// s_tready drops only while both the output register and the skid register hold words
// async active-low reset: framing idle, shadows and held position record zero
`default_nettype none

module nmea_sentence_parser #(
    parameter int MAX_FIELDS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted, latitude_micro, lat_south, longitude_micro, lon_west,
    // altitude_dm, hdop_centi, satellites, fix_valid, utc_centis, zero pad
    output logic [127:0]      m_tdata,
    output logic [1:0]        m_tuser    // sentence_kind
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             res_valid;
    nsp_pkg::result_t res;
    logic             out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    nsp_pkg::result_t out_data_reg, out_data_next, skid_data_reg, skid_data_next;
    logic             out_free;

    assign s_tready = !skid_valid_reg;

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= s_tdata;
    end

    nsp_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid slot
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next = res;
            end else begin
                out_valid_next = res_valid;
                out_data_next = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.sentence_kind;
    assign m_tdata  = {3'd0,
                       out_data_reg.utc_centis,
                       out_data_reg.fix_valid,
                       out_data_reg.satellites,
                       out_data_reg.hdop_centi,
                       out_data_reg.altitude_dm,
                       out_data_reg.lon_west,
                       out_data_reg.longitude_micro,
                       out_data_reg.lat_south,
                       out_data_reg.latitude_micro,
                       out_data_reg.accepted};

endmodule

`default_nettype wire

/* sv/nsp_checker.sv */
// port-level checks of the nmea sentence parser and their bind
`default_nettype none

`include "nmea_sentence_parser_macros.svh"

module nsp_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [7:0]   s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // a stalled word stays offered
    `NSP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

    // input backpressure only follows a stalled output
    `NSP_ASSERT_NOW(a_ready, !s_tready, $past(m_tvalid && !m_tready), "input stalled without cause")

    // only known sentences give a word
    `NSP_ASSERT_NOW(a_kind, m_tvalid, m_tuser != nsp_pkg::KIND_NONE, "unknown sentence kind")

    // gsa words are always accepted
    `NSP_ASSERT_NOW(a_gsa, m_tvalid && m_tuser == nsp_pkg::KIND_GSA, m_tdata[0], "gsa not accepted")

    // held latitude never beyond ninety degrees
    `NSP_ASSERT_NOW(a_lat, m_tvalid, m_tdata[27:1] <= 27'd90000000, "latitude out of range")

endmodule

bind nmea_sentence_parser nsp_checker u_nsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* test/nsp_checker.sv */
// checker for the nmea sentence parser: byte-level sentence predictor and result compare
`timescale 1ns / 100ps
`default_nettype none

module tb_nsp_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                fail_count,
    output int                pending_count,
    output int                record_count
);

    localparam int FIELD_LIMIT = 32;

    // sentence framing and shadow state
    nsp_pkg::phase_t phase;
    logic [7:0]  run_xor;
    logic [7:0]  rx_sum;
    int          fld;
    int          col;
    logic [39:0] addr_word;
    logic [1:0]  kind;
    longint      deg [2];
    longint      milli [2];
    longint      qual_fix;
    longint      sats_sh;
    longint      hdop_sh;
    longint      alt_sh;
    logic [7:0]  side [2];
    int          prn_seen;
    longint      utc_sh;
    logic        alt_nz, hdop_nz, deg_halt;

    // number scanner
    logic   n_neg, n_dot, n_stop, n_nz, n_any;
    int     n_frac;
    longint n_int, n_fracval;

    // held position record
    longint hold_lat, hold_lon, hold_alt, hold_hdop, hold_utc, hold_sats;
    logic   hold_fix, hold_south, hold_west;

    nsp_pkg::result_t expected_records [$];
    int               errors;

    assign fail_count = errors;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= nsp_pkg::CH_0 && c <= nsp_pkg::CH_9;
    endfunction

    task automatic scan_clear();
        n_neg = 0; n_dot = 0; n_stop = 0; n_nz = 0; n_any = 0;
        n_frac = 0; n_int = 0; n_fracval = 0;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic sign_ok, input logic dot_ok,
                             input int frac_max);
        longint v;
        if (n_stop) return;
        if ((c == nsp_pkg::CH_MINUS || c == nsp_pkg::CH_PLUS) && sign_ok && !n_any) begin
            n_neg = (c == nsp_pkg::CH_MINUS);
        end else if (is_dig(c)) begin
            if (c != nsp_pkg::CH_0) n_nz = 1;
            if (!n_dot) begin
                v = n_int * 10 + (c - nsp_pkg::CH_0);
                n_int = (v > nsp_pkg::INT_CAP) ? nsp_pkg::INT_CAP : v;
            end else if (n_frac < frac_max) begin
                n_fracval = n_fracval * 10 + (c - nsp_pkg::CH_0);
                n_frac++;
            end
        end else if (c == nsp_pkg::CH_DOT && dot_ok && !n_dot) begin
            n_dot = 1;
        end else begin
            n_stop = 1;
            return;
        end
        n_any = 1;
    endtask

    function automatic longint scan_scaled(input int f);
        longint a, b;
        a = n_int;
        b = n_fracval;
        for (int i = 0; i < f; i++) a = a * 10;
        for (int i = n_frac; i < f; i++) b = b * 10;
        return a + b;
    endfunction

    task automatic sentence_clear();
        run_xor = 0; rx_sum = 0; fld = 0; col = 0;
        addr_word = 0; kind = nsp_pkg::KIND_NONE;
        deg[0] = 0; deg[1] = 0; milli[0] = 0; milli[1] = 0;
        qual_fix = 0; sats_sh = 0; hdop_sh = 0; alt_sh = 0;
        side[0] = 0; side[1] = 0; prn_seen = 0; utc_sh = 0;
        alt_nz = 0; hdop_nz = 0; deg_halt = 0;
        scan_clear();
    endtask

    // what the current field means for the sentence kind
    function automatic nsp_pkg::role_t field_role();
        if (fld == 0) return nsp_pkg::R_ADDR;
        if (kind == nsp_pkg::KIND_GGA) begin
            case (fld)
                1: return nsp_pkg::R_TIME;
                2: return nsp_pkg::R_LAT;
                3: return nsp_pkg::R_SIDE0;
                4: return nsp_pkg::R_LON;
                5: return nsp_pkg::R_SIDE1;
                6: return nsp_pkg::R_QUAL;
                7: return nsp_pkg::R_SATS;
                8: return nsp_pkg::R_HDOP;
                9: return nsp_pkg::R_ALT;
                default: return nsp_pkg::R_NONE;
            endcase
        end
        if (kind == nsp_pkg::KIND_GLL) begin
            case (fld)
                1: return nsp_pkg::R_LAT;
                2: return nsp_pkg::R_SIDE0;
                3: return nsp_pkg::R_LON;
                4: return nsp_pkg::R_SIDE1;
                default: return nsp_pkg::R_NONE;
            endcase
        end
        if (kind == nsp_pkg::KIND_GSA) begin
            if (fld == 2) return nsp_pkg::R_GSAFIX;
            if (fld >= 3 && fld <= 14) return nsp_pkg::R_PRN;
        end
        return nsp_pkg::R_NONE;
    endfunction

    // degrees come first, then six characters of minutes
    task automatic coord_char(input int slot, input int dlen, input logic [7:0] c);
        if (col < dlen) begin
            if (deg_halt) return;
            if (is_dig(c)) deg[slot] = deg[slot] * 10 + (c - nsp_pkg::CH_0);
            else deg_halt = 1;
        end else if (col < dlen + 6) begin
            scan_char(c, 0, 1, 3);
        end
    endtask

    task automatic body_char(input logic [7:0] c);
        case (field_role())
            nsp_pkg::R_ADDR:   if (col < 5) addr_word = {addr_word[31:0], c};
            nsp_pkg::R_TIME:   scan_char(c, 0, 1, 2);
            nsp_pkg::R_LAT:    coord_char(0, 2, c);
            nsp_pkg::R_LON:    coord_char(1, 3, c);
            nsp_pkg::R_SIDE0:  if (col == 0) side[0] = c;
            nsp_pkg::R_SIDE1:  if (col == 0) side[1] = c;
            nsp_pkg::R_QUAL, nsp_pkg::R_SATS, nsp_pkg::R_GSAFIX: scan_char(c, 1, 0, 0);
            nsp_pkg::R_HDOP:   scan_char(c, 1, 1, 2);
            nsp_pkg::R_ALT:    scan_char(c, 1, 1, 1);
            default:  ;
        endcase
        if (col < 15) col++;
    endtask

    task automatic close_field();
        longint v;
        nsp_pkg::role_t r;
        r = field_role();
        case (r)
            nsp_pkg::R_ADDR: begin
                if (col == 5) begin
                    if (addr_word == nsp_pkg::ADDR_GNGGA) kind = nsp_pkg::KIND_GGA;
                    else if (addr_word == nsp_pkg::ADDR_GNGLL) kind = nsp_pkg::KIND_GLL;
                    else if (addr_word == nsp_pkg::ADDR_GPGSA) kind = nsp_pkg::KIND_GSA;
                end
            end
            nsp_pkg::R_TIME: begin
                v = (n_int / 10000) * 360000 + ((n_int / 100) % 100) * 6000
                    + (n_int % 100) * 100 + scan_scaled(2) % 100;
                utc_sh = (v > nsp_pkg::UTC_MAX) ? nsp_pkg::UTC_MAX : v;
            end
            nsp_pkg::R_LAT, nsp_pkg::R_LON: begin
                v = scan_scaled(3);
                milli[(r == nsp_pkg::R_LAT) ? 0 : 1] =
                    (v > nsp_pkg::MILLI_MAX) ? nsp_pkg::MILLI_MAX : v;
            end
            nsp_pkg::R_QUAL:   qual_fix = (!n_neg && n_int > 0) ? 1 : 0;
            nsp_pkg::R_GSAFIX: qual_fix = (!n_neg && n_int > 1) ? 1 : 0;
            nsp_pkg::R_SATS:
                sats_sh = n_neg ? 0 : ((n_int > nsp_pkg::SATS_MAX) ? nsp_pkg::SATS_MAX : n_int);
            nsp_pkg::R_HDOP: begin
                hdop_nz = n_nz;
                v = scan_scaled(2);
                hdop_sh = n_neg ? 0 : ((v > nsp_pkg::HDOP_MAX) ? nsp_pkg::HDOP_MAX : v);
            end
            nsp_pkg::R_ALT: begin
                alt_nz = n_nz;
                v = scan_scaled(1);
                if (n_neg)
                    alt_sh = (v > nsp_pkg::ALT_LO_MAG) ? -longint'(nsp_pkg::ALT_LO_MAG) : -v;
                else alt_sh = (v > nsp_pkg::ALT_HI) ? nsp_pkg::ALT_HI : v;
            end
            nsp_pkg::R_PRN: if (col > 0) prn_seen++;
            default: ;
        endcase
        fld++;
        col = 0;
        deg_halt = 0;
        scan_clear();
    endtask

    // per-type checks and update of the held record
    function automatic logic record_update();
        logic   side_ok;
        longint lat, lon;
        side_ok = side[0] == nsp_pkg::CH_S || side[0] == nsp_pkg::CH_N;
        lat = deg[0] * 1000000 + milli[0] * 1000 / 60;
        lon = deg[1] * 1000000 + milli[1] * 1000 / 60;
        if (kind == nsp_pkg::KIND_GSA) begin
            hold_fix = qual_fix != 0;
            hold_sats = prn_seen;
            return 1;
        end
        if (kind == nsp_pkg::KIND_GLL) begin
            if (!side_ok || deg[0] == 0 || deg[1] == 0 || milli[0] == 0 || milli[1] == 0)
                return 0;
            hold_lat = (lat > nsp_pkg::LAT_MAX) ? nsp_pkg::LAT_MAX : lat;
            hold_lon = (lon > nsp_pkg::LON_MAX) ? nsp_pkg::LON_MAX : lon;
            hold_south = side[0] == nsp_pkg::CH_S;
            hold_west = side[1] == nsp_pkg::CH_W;
            return 1;
        end
        hold_utc = utc_sh;
        if (!side_ok || lat == 0 || lon == 0 || lat >= nsp_pkg::LAT_MAX ||
            lon >= nsp_pkg::LON_MAX) return 0;
        hold_lat = lat;
        hold_lon = lon;
        hold_south = side[0] == nsp_pkg::CH_S;
        hold_west = side[1] == nsp_pkg::CH_W;
        if (alt_nz) hold_alt = alt_sh;
        hold_sats = sats_sh;
        hold_fix = qual_fix != 0;
        if (hdop_nz) hold_hdop = hdop_sh;
        return 1;
    endfunction

    // advance the sentence state by one byte, queue a record when a sentence completes
    task automatic parse_byte(input logic [7:0] c);
        logic [4:0]       h;
        nsp_pkg::result_t rec;
        logic             ok;
        h = 0;
        if (c >= nsp_pkg::CH_0 && c <= nsp_pkg::CH_9)
            h = {1'b1, 4'(c - nsp_pkg::CH_0)};
        else if (c >= nsp_pkg::CH_UA && c <= nsp_pkg::CH_UF)
            h = {1'b1, 4'(c - nsp_pkg::CH_UA + 10)};
        else if (c >= nsp_pkg::CH_LA && c <= nsp_pkg::CH_LF_HEX)
            h = {1'b1, 4'(c - nsp_pkg::CH_LA + 10)};
        if (c == nsp_pkg::CH_DOLLAR) begin
            sentence_clear();
            phase = nsp_pkg::PH_BODY;
            return;
        end
        case (phase)
            nsp_pkg::PH_BODY: begin
                if (c == nsp_pkg::CH_STAR) begin
                    close_field();
                    phase = nsp_pkg::PH_HEX_HI;
                end else if (c == nsp_pkg::CH_CR || c == nsp_pkg::CH_LF) begin
                    phase = nsp_pkg::PH_IDLE;
                end else begin
                    run_xor ^= c;
                    if (c == nsp_pkg::CH_COMMA) begin
                        if (fld + 1 >= FIELD_LIMIT) phase = nsp_pkg::PH_IDLE;
                        else close_field();
                    end else begin
                        body_char(c);
                    end
                end
            end
            nsp_pkg::PH_HEX_HI: begin
                if (!h[4]) phase = nsp_pkg::PH_IDLE;
                else begin
                    rx_sum = {h[3:0], 4'h0};
                    phase = nsp_pkg::PH_HEX_LO;
                end
            end
            nsp_pkg::PH_HEX_LO: begin
                if (!h[4]) phase = nsp_pkg::PH_IDLE;
                else begin
                    rx_sum[3:0] = h[3:0];
                    phase = nsp_pkg::PH_WAIT_CR;
                end
            end
            nsp_pkg::PH_WAIT_CR:
                phase = (c == nsp_pkg::CH_CR) ? nsp_pkg::PH_WAIT_LF : nsp_pkg::PH_IDLE;
            nsp_pkg::PH_WAIT_LF: begin
                phase = nsp_pkg::PH_IDLE;
                if (c == nsp_pkg::CH_LF && run_xor == rx_sum && kind != nsp_pkg::KIND_NONE) begin
                    ok = record_update();
                    rec.sentence_kind   = kind;
                    rec.accepted        = ok;
                    rec.latitude_micro  = 27'(hold_lat);
                    rec.lat_south       = hold_south;
                    rec.longitude_micro = 28'(hold_lon);
                    rec.lon_west        = hold_west;
                    rec.altitude_dm     = 21'(hold_alt);
                    rec.hdop_centi      = 14'(hold_hdop);
                    rec.satellites      = 7'(hold_sats);
                    rec.fix_valid       = hold_fix;
                    rec.utc_centis      = 24'(hold_utc);
                    expected_records.push_back(rec);
                end
            end
            default: phase = nsp_pkg::PH_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout logic bad);
        if (want !== got) begin
            if (errors < 10)
                $display("%0t mismatch %s: expected %0d got %0d", $realtime, name, want, got);
            bad = 1;
        end
    endtask

    // compare one output word with the oldest expected record
    task automatic compare_record();
        nsp_pkg::result_t want;
        logic             bad;
        bad = 0;
        if (expected_records.size() == 0) begin
            if (errors < 10) $display("%0t unexpected output word", $realtime);
            errors++;
            return;
        end
        want = expected_records.pop_front();
        check_field("sentence_kind", want.sentence_kind, m_tuser, bad);
        check_field("accepted", want.accepted, m_tdata[0], bad);
        check_field("latitude_micro", want.latitude_micro, m_tdata[27:1], bad);
        check_field("lat_south", want.lat_south, m_tdata[28], bad);
        check_field("longitude_micro", want.longitude_micro, m_tdata[56:29], bad);
        check_field("lon_west", want.lon_west, m_tdata[57], bad);
        check_field("altitude_dm", 32'(want.altitude_dm), 32'($signed(m_tdata[78:58])), bad);
        check_field("hdop_centi", want.hdop_centi, m_tdata[92:79], bad);
        check_field("satellites", want.satellites, m_tdata[99:93], bad);
        check_field("fix_valid", want.fix_valid, m_tdata[100], bad);
        check_field("utc_centis", want.utc_centis, m_tdata[124:101], bad);
        if (bad) errors++;
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase = nsp_pkg::PH_IDLE;
            sentence_clear();
            hold_lat = 0; hold_lon = 0; hold_alt = 0; hold_hdop = 0;
            hold_utc = 0; hold_sats = 0;
            hold_fix = 0; hold_south = 0; hold_west = 0;
            expected_records.delete();
            errors = 0;
            record_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                compare_record();
                record_count++;
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
        pending_count = expected_records.size();
    end

endmodule

`default_nettype wire

/* test/tb_nmea_sentence_parser.sv */
// testbench top for the nmea sentence parser: sentence stimulus, stalls and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_nmea_sentence_parser;

    localparam longint CYCLE_LIMIT = 3000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    int     fail_count;
    int     pending_count;
    int     record_count;
    longint cycles = 0;
    logic   calm;
    int     stall_left;
    int     bytes_sent;
    int     good_sentences;

    nmea_sentence_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tb_nsp_checker u_tb_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .record_count  (record_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (!rst_n || calm) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one word on the input channel, with an occasional idle burst first
    task automatic put_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) put_byte(t[i]);
    endtask

    // framed sentence; flaw selects a way to break the tail
    task automatic put_sentence(input string body, input int flaw);
        logic [7:0] x;
        string      hx;
        x = 0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        hx = ($urandom_range(0, 3) == 0) ? $sformatf("%02x", x) : $sformatf("%02X", x);
        put_byte(nsp_pkg::CH_DOLLAR);
        put_text(body);
        case (flaw)
            0: begin
                put_text({"*", hx});
                put_byte(nsp_pkg::CH_CR);
                put_byte(nsp_pkg::CH_LF);
            end
            1: begin
                put_text({"*", $sformatf("%02X", x ^ 8'(1 << $urandom_range(0, 7)))});
                put_byte(nsp_pkg::CH_CR);
                put_byte(nsp_pkg::CH_LF);
            end
            2: begin
                put_text("*G1");
                put_byte(nsp_pkg::CH_CR);
                put_byte(nsp_pkg::CH_LF);
            end
            3: begin
                put_text({"*", hx});
                put_byte(nsp_pkg::CH_LF);
            end
            4: put_byte(nsp_pkg::CH_CR);
            5: begin
                put_text({"*", hx});
                put_byte(nsp_pkg::CH_CR);
                put_byte(8'h20);
            end
            default: put_text("*4");
        endcase
    endtask

    function automatic string digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(nsp_pkg::CH_0 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string maybe_sign();
        case ($urandom_range(0, 5))
            0: return "-";
            1: return "+";
            default: return "";
        endcase
    endfunction

    // numbers with optional sign, fraction and trailing junk
    function automatic string rand_number(input int idig);
        string s;
        s = {maybe_sign(), digits($urandom_range(0, idig))};
        if ($urandom_range(0, 1)) s = {s, ".", digits($urandom_range(0, 4))};
        if ($urandom_range(0, 9) == 0) s = {s, "x", digits(1)};
        if ($urandom_range(0, 11) == 0) s = "";
        return s;
    endfunction

    function automatic string rand_coord(input int dlen);
        string s;
        if ($urandom_range(0, 11) == 0) return "";
        s = {digits(dlen), digits(2)};
        if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, 6))};
        if ($urandom_range(0, 15) == 0) s = {"1A", s};
        return s;
    endfunction

    function automatic string rand_side(input logic lat);
        case ($urandom_range(0, 9))
            0: return "";
            1: return "X";
            2, 3, 4: return lat ? "N" : "E";
            default: return lat ? "S" : "W";
        endcase
    endfunction

    function automatic string rand_time();
        if ($urandom_range(0, 9) == 0) return rand_number(8);
        return $sformatf("%02d%02d%02d.%s", $urandom_range(0, 29), $urandom_range(0, 99),
                         $urandom_range(0, 99), digits($urandom_range(0, 3)));
    endfunction

    function automatic string rand_body();
        string s;
        case ($urandom_range(0, 2))
            0: s = {"GNGGA,", rand_time(), ",", rand_coord(2), ",", rand_side(1), ",",
                    rand_coord(3), ",", rand_side(0), ",", rand_number(2), ",",
                    rand_number(3), ",", rand_number(5), ",", rand_number(7), ",M,,M,,"};
            1: s = {"GNGLL,", rand_coord(2), ",", rand_side(1), ",", rand_coord(3), ",",
                    rand_side(0), ",", rand_time(), ",A,A"};
            default: begin
                s = {"GPGSA,A,", rand_number(1)};
                for (int i = 0; i < 12; i++)
                    s = {s, ",", ($urandom_range(0, 2) == 0) ? "" : digits(2)};
                s = {s, ",1.5,", rand_number(2), ",2.1"};
            end
        endcase
        return s;
    endfunction

    initial
    begin
        string big;
        int    flaw;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        calm = 0;
        bytes_sent = 0;
        good_sentences = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sentences: nominal, extremes and framing faults
        put_sentence("GNGGA,123519.25,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 0);
        put_sentence("GNGLL,4916.45,S,12311.12,W,225444,A,A", 0);
        put_sentence("GPGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1", 0);
        put_sentence("GNGLL,9959.999,N,99959.999,W", 0);
        put_sentence("GNGLL,0012.5,N,01131.0,E", 0);
        put_sentence("GNGGA,999999.99,8959.99999,S,17959.9999,W,-3,-5,-2.5,-99999.9,M", 0);
        put_sentence("GNGGA,000000.00,0000.001,N,00000.001,E,9,999,99999,99999999.9", 0);
        put_sentence("GNGGA,1,9000.000,N,01131.0,E,1,1,0.00,0.0", 0);
        put_sentence("GNGGA,235959.99,1234.5,Q,01131.0,E,1,4,1.0,10", 0);
        put_sentence("GPGSA,+A,-4,01,02,03,04,05,06,07,08,09,10,11,12,1,1,1", 0);
        put_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08", 0);
        put_sentence("GNGGAX,123519,4807.038,N,01131.000,E,1,08", 0);
        put_sentence("GNGLL,4916.45,N,12311.12,E", 1);
        put_sentence("GNGLL,4916.45,N,12311.12,E", 2);
        put_sentence("GNGLL,4916.45,N,12311.12,E", 3);
        put_sentence("GNGLL,4916.45,N,12311.12,E", 4);
        put_sentence("GNGLL,4916.45,N,12311.12,E", 5);
        put_text("$GNGLL,4916.45,N");
        put_sentence("GPSA,A,2,01", 0);
        big = "GPGSA,A,3";
        for (int i = 0; i < 32; i++) big = {big, ",1"};
        put_sentence(big, 0);
        put_text("junk,*12\r\n");
        put_sentence("GNGGA,1", 0);

        // hold off until the parser has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        // random sentences, mostly well formed, with noise between them
        while (bytes_sent < 2000) begin
            if (bytes_sent > 1700) calm = 1;
            case ($urandom_range(0, 15))
                0: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
                1, 2: begin
                    flaw = $urandom_range(1, 6);
                    put_sentence(rand_body(), flaw);
                end
                default: begin
                    put_sentence(rand_body(), 0);
                    good_sentences++;
                end
            endcase
        end
        s_tvalid <= 1'b0;
        calm = 1;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d bytes, %0d well formed sentences, %0d result words checked",
                 bytes_sent, good_sentences, record_count);
        $display("coverage: gga/gll/gsa fields, saturation, framing faults, random stalls");
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
